### src/salb_pkg.sv
`timescale 1ns / 1ps

package salb_pkg;

   localparam int LIST_CAPACITY_DEFAULT = 124;
   localparam int SLOT_COUNT_DEFAULT    = 32;

   localparam int SLOT_WIDTH   = 5;
   localparam int BYTE_WIDTH   = 8;
   localparam int COUNT_WIDTH  = 7;
   localparam int CODE_WIDTH   = 9;
   localparam int COORD_WIDTH  = 9;
   localparam int COLOR_WIDTH  = 4;
   localparam int COLUMN_WIDTH = 2;
   localparam int LIMIT_WIDTH  = SLOT_WIDTH + 1;

   localparam int COLUMN_STEP    = 16;
   localparam int COLUMN_SHIFT   = $clog2(COLUMN_STEP);
   localparam int SCREEN_WIDTH   = 224;
   localparam int SCREEN_LIMIT_Y = 288;
   localparam int X_BIAS         = 16;
   localparam int Y_BASE         = 256;
   localparam int X_LIMIT_RAW    = SCREEN_WIDTH + X_BIAS;

   localparam int LEFT_SLOT_FIRST = 8;
   localparam int LEFT_SLOT_END   = 16;
   localparam int RIGHT_SLOT_END  = 8;

   localparam int ATTR_FOUR_BIT = 7;
   localparam int ATTR_TWO_BIT  = 6;
   localparam int ATTR_CODE_BIT = 5;
   localparam int ATTR_Y_BIT    = 4;
   localparam int CODE_BANK_BIT = 7;

   localparam logic [COLUMN_WIDTH-1:0] LAST_COLUMN_ONE  = 2'd0;
   localparam logic [COLUMN_WIDTH-1:0] LAST_COLUMN_TWO  = 2'd1;
   localparam logic [COLUMN_WIDTH-1:0] LAST_COLUMN_FOUR = 2'd3;

   typedef struct packed {
      logic [SLOT_WIDTH-1:0] slot_index;
      logic [BYTE_WIDTH-1:0] code_byte;
      logic [BYTE_WIDTH-1:0] attribute_byte;
      logic [BYTE_WIDTH-1:0] horizontal_byte;
      logic [BYTE_WIDTH-1:0] vertical_byte;
   } entry_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0]        slot;
      logic [BYTE_WIDTH-1:0]         code;
      logic                          bank;
      logic [COLOR_WIDTH-1:0]        color;
      logic signed [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0]        y;
      logic                          left;
      logic                          right;
      logic [COLUMN_WIDTH-1:0]       last_column;
   } descriptor_type;

endpackage

### src/salb_decode.sv
`timescale 1ns / 1ps

module salb_decode #(
   parameter int LIST_CAPACITY = salb_pkg::LIST_CAPACITY_DEFAULT,
   parameter int SLOT_COUNT    = salb_pkg::SLOT_COUNT_DEFAULT
) (
   input  salb_pkg::entry_type                    entry,
   input  logic [salb_pkg::COUNT_WIDTH-1:0]       count,
   output logic                                   live,
   output salb_pkg::descriptor_type               descriptor,
   output logic [salb_pkg::COUNT_WIDTH-1:0]       count_next
);

   logic [salb_pkg::COUNT_WIDTH-1:0]  base;
   logic                              slot_ok;
   logic                              room;
   logic                              used;
   logic                              x_ok;
   logic                              y_ok;
   logic [salb_pkg::COORD_WIDTH:0]    y_wide;
   logic [3:1]                        fits;
   logic [salb_pkg::COLUMN_WIDTH-1:0] wanted;
   logic [salb_pkg::COLUMN_WIDTH-1:0] last_column;

   always_comb begin
      base    = (entry.slot_index == '0) ? '0 : count;
      slot_ok = {1'b0, entry.slot_index} < salb_pkg::LIMIT_WIDTH'(SLOT_COUNT);
      room    = base < salb_pkg::COUNT_WIDTH'(LIST_CAPACITY);
      used    = (entry.horizontal_byte != '0) && (entry.vertical_byte != '0);
      x_ok    = {1'b0, entry.horizontal_byte} < 9'(salb_pkg::X_LIMIT_RAW);
      y_wide  = 10'(salb_pkg::Y_BASE)
              + {1'b0, entry.attribute_byte[salb_pkg::ATTR_Y_BIT], 8'b0}
              - {2'b0, entry.vertical_byte};
      y_ok    = y_wide < 10'(salb_pkg::SCREEN_LIMIT_Y);
      for (int k = 1; k <= 3; k++) begin
         fits[k] = {1'b0, entry.horizontal_byte} + 9'(salb_pkg::COLUMN_STEP * k)
                 < 9'(salb_pkg::X_LIMIT_RAW);
      end
      if (entry.attribute_byte[salb_pkg::ATTR_FOUR_BIT]) begin
         wanted = salb_pkg::LAST_COLUMN_FOUR;
      end else if (entry.attribute_byte[salb_pkg::ATTR_TWO_BIT]) begin
         wanted = salb_pkg::LAST_COLUMN_TWO;
      end else begin
         wanted = salb_pkg::LAST_COLUMN_ONE;
      end
      priority if (wanted >= 2'd1 && !fits[1]) begin
         last_column = 2'd0;
      end else if (wanted >= 2'd2 && !fits[2]) begin
         last_column = 2'd1;
      end else if (wanted == 2'd3 && !fits[3]) begin
         last_column = 2'd2;
      end else begin
         last_column = wanted;
      end
      live       = slot_ok && room && used && x_ok && y_ok;
      count_next = live ? salb_pkg::COUNT_WIDTH'(base + last_column + 1'b1) : base;

      descriptor.slot        = base;
      descriptor.code        = {entry.attribute_byte[salb_pkg::ATTR_CODE_BIT],
                                entry.code_byte[6:0]};
      descriptor.bank        = entry.code_byte[salb_pkg::CODE_BANK_BIT];
      descriptor.color       = entry.attribute_byte[salb_pkg::COLOR_WIDTH-1:0];
      descriptor.x           = $signed({1'b0, entry.horizontal_byte} - 9'(salb_pkg::X_BIAS));
      descriptor.y           = y_wide[salb_pkg::COORD_WIDTH-1:0];
      descriptor.left        = (entry.slot_index >= 5'(salb_pkg::LEFT_SLOT_FIRST))
                            && (entry.slot_index < 5'(salb_pkg::LEFT_SLOT_END));
      descriptor.right       = entry.slot_index < 5'(salb_pkg::RIGHT_SLOT_END);
      descriptor.last_column = last_column;
   end

endmodule

### src/salb_emit.sv
`timescale 1ns / 1ps

module salb_emit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  salb_pkg::descriptor_type               load_descriptor,
   output logic                                   free,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [salb_pkg::COUNT_WIDTH-1:0]       rsp_descriptor_slot,
   output logic [salb_pkg::CODE_WIDTH-1:0]        rsp_pattern_code,
   output logic                                   rsp_pattern_bank,
   output logic [salb_pkg::COLOR_WIDTH-1:0]       rsp_color_group,
   output logic signed [salb_pkg::COORD_WIDTH-1:0] rsp_x_position,
   output logic [salb_pkg::COORD_WIDTH-1:0]       rsp_y_position,
   output logic                                   rsp_limit_left_region,
   output logic                                   rsp_limit_right_region,
   output logic                                   rsp_last_of_entry
);

   logic                              valid_ff;
   logic                              valid_in;
   logic [salb_pkg::COLUMN_WIDTH-1:0] column_ff;
   logic [salb_pkg::COLUMN_WIDTH-1:0] column_in;
   salb_pkg::descriptor_type          desc_ff;
   salb_pkg::descriptor_type          desc_in;
   logic                              final_column;
   logic                              take;

   always_comb begin
      final_column = column_ff == desc_ff.last_column;
      take         = valid_ff && !rsp_stall;
      free         = !valid_ff || (take && final_column);
      valid_in     = load ? 1'b1 : (free ? 1'b0 : valid_ff);
      column_in    = load ? '0 : (take ? column_ff + 1'b1 : column_ff);
      desc_in      = load ? load_descriptor : desc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      column_ff <= column_in;
      desc_ff   <= desc_in;
   end

   always_comb begin
      rsp_valid              = valid_ff;
      rsp_descriptor_slot    = desc_ff.slot + salb_pkg::COUNT_WIDTH'(column_ff);
      rsp_pattern_code       = salb_pkg::CODE_WIDTH'(desc_ff.code)
                             + salb_pkg::CODE_WIDTH'(column_ff);
      rsp_pattern_bank       = desc_ff.bank;
      rsp_color_group        = desc_ff.color;
      rsp_x_position         = desc_ff.x + $signed(salb_pkg::COORD_WIDTH'(column_ff)
                                                   << salb_pkg::COLUMN_SHIFT);
      rsp_y_position         = desc_ff.y;
      rsp_limit_left_region  = desc_ff.left;
      rsp_limit_right_region = desc_ff.right;
      rsp_last_of_entry      = final_column;
   end

endmodule

### src/sprite_attribute_list_builder.sv
`timescale 1ns / 1ps
// A word is taken into the input register and decoded on its way into the result register.
// Its first descriptor shows once the result register loads it; an unstalled edge takes it.
// The result register sends one descriptor a cycle unless rsp_stall holds it; a word yields one
// to four descriptors; a word that yields nothing leaves the input register and loads nothing.
// Synchronous reset clears the valid flags and the descriptor count; no other start-up is needed.

module sprite_attribute_list_builder #(
   parameter int LIST_CAPACITY = salb_pkg::LIST_CAPACITY_DEFAULT,
   parameter int SLOT_COUNT    = salb_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [salb_pkg::SLOT_WIDTH-1:0]        req_slot_index,
   input  logic [salb_pkg::BYTE_WIDTH-1:0]        req_code_byte,
   input  logic [salb_pkg::BYTE_WIDTH-1:0]        req_attribute_byte,
   input  logic [salb_pkg::BYTE_WIDTH-1:0]        req_horizontal_byte,
   input  logic [salb_pkg::BYTE_WIDTH-1:0]        req_vertical_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [salb_pkg::COUNT_WIDTH-1:0]       rsp_descriptor_slot,
   output logic [salb_pkg::CODE_WIDTH-1:0]        rsp_pattern_code,
   output logic                                   rsp_pattern_bank,
   output logic [salb_pkg::COLOR_WIDTH-1:0]       rsp_color_group,
   output logic signed [salb_pkg::COORD_WIDTH-1:0] rsp_x_position,
   output logic [salb_pkg::COORD_WIDTH-1:0]       rsp_y_position,
   output logic                                   rsp_limit_left_region,
   output logic                                   rsp_limit_right_region,
   output logic                                   rsp_last_of_entry
);

   logic                             entry_valid_ff;
   logic                             entry_valid_in;
   salb_pkg::entry_type              entry_ff;
   salb_pkg::entry_type              entry_in;
   logic [salb_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [salb_pkg::COUNT_WIDTH-1:0] count_in;
   logic [salb_pkg::COUNT_WIDTH-1:0] count_next;
   logic                             live;
   salb_pkg::descriptor_type         descriptor;
   logic                             free;
   logic                             accept;
   logic                             move;

   salb_decode #(
      .LIST_CAPACITY(LIST_CAPACITY),
      .SLOT_COUNT   (SLOT_COUNT)
   ) u_decode (
      .entry     (entry_ff),
      .count     (count_ff),
      .live      (live),
      .descriptor(descriptor),
      .count_next(count_next)
   );

   salb_emit u_emit (
      .clock                 (clock),
      .reset                 (reset),
      .load                  (move && live),
      .load_descriptor       (descriptor),
      .free                  (free),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_descriptor_slot   (rsp_descriptor_slot),
      .rsp_pattern_code      (rsp_pattern_code),
      .rsp_pattern_bank      (rsp_pattern_bank),
      .rsp_color_group       (rsp_color_group),
      .rsp_x_position        (rsp_x_position),
      .rsp_y_position        (rsp_y_position),
      .rsp_limit_left_region (rsp_limit_left_region),
      .rsp_limit_right_region(rsp_limit_right_region),
      .rsp_last_of_entry     (rsp_last_of_entry)
   );

   always_comb begin
      move           = entry_valid_ff && free;
      req_stall      = entry_valid_ff && !free;
      accept         = req_valid && !req_stall;
      entry_valid_in = accept ? 1'b1 : (move ? 1'b0 : entry_valid_ff);
      count_in       = move ? count_next : count_ff;
      if (accept) begin
         entry_in.slot_index      = req_slot_index;
         entry_in.code_byte       = req_code_byte;
         entry_in.attribute_byte  = req_attribute_byte;
         entry_in.horizontal_byte = req_horizontal_byte;
         entry_in.vertical_byte   = req_vertical_byte;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
         count_ff       <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### src/salb_checker.sv
`timescale 1ns / 1ps

module salb_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic [salb_pkg::COUNT_WIDTH-1:0]       rsp_descriptor_slot,
   input logic [salb_pkg::CODE_WIDTH-1:0]        rsp_pattern_code,
   input logic [salb_pkg::COLOR_WIDTH-1:0]       rsp_color_group,
   input logic signed [salb_pkg::COORD_WIDTH-1:0] rsp_x_position,
   input logic [salb_pkg::COORD_WIDTH-1:0]       rsp_y_position,
   input logic                                   rsp_limit_left_region,
   input logic                                   rsp_limit_right_region,
   input logic                                   rsp_last_of_entry
);

   // Within one entry the descriptors follow each other with no gap and consecutive numbers.
   a_next_column : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_entry |=>
         rsp_valid
         && rsp_descriptor_slot == $past(rsp_descriptor_slot) + 7'd1
         && rsp_pattern_code == $past(rsp_pattern_code) + 9'd1)
      else $error("descriptor slot or pattern code did not advance within an entry");

   a_column_step : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_entry |=>
         rsp_x_position == $past(rsp_x_position) + 9'(salb_pkg::COLUMN_STEP)
         && $stable(rsp_y_position) && $stable(rsp_color_group))
      else $error("column step or shared fields wrong within an entry");

   a_on_screen : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_x_position < $signed(9'(salb_pkg::SCREEN_WIDTH))
         && rsp_x_position > -$signed(9'(salb_pkg::X_BIAS))
         && rsp_y_position != '0
         && !(rsp_limit_left_region && rsp_limit_right_region))
      else $error("descriptor off screen or in both regions");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_descriptor_slot) && $stable(rsp_pattern_code)
         && $stable(rsp_last_of_entry))
      else $error("stalled word changed");

endmodule

bind sprite_attribute_list_builder salb_checker u_salb_checker (.*);
